FILE: hw/rtl/gsa_pkg.sv
package gsa_pkg;

   localparam int SLOTS     = 1024;
   localparam int GEN_WIDTH = 32;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int TOP_W     = $clog2(SLOTS + 1);

   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;

   localparam logic [2:0] STAT_OK           = 3'd0;
   localparam logic [2:0] STAT_EXHAUSTED    = 3'd1;
   localparam logic [2:0] STAT_INVALID      = 3'd2;
   localparam logic [2:0] STAT_WRONG_KIND   = 3'd3;
   localparam logic [2:0] STAT_OUT_OF_RANGE = 3'd4;
   localparam logic [2:0] STAT_STALE        = 3'd5;
   localparam logic [2:0] STAT_ALREADY_FREE = 3'd6;

   localparam int REG_POOL_KIND = 0;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        handle_kind;
      logic [11:0] handle_slot;
      logic [31:0] handle_generation;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        out_kind;
      logic [9:0]  out_slot;
      logic [31:0] out_generation;
      logic [10:0] free_count;
      logic [10:0] allocated_count;
      logic [31:0] alloc_ok_count;
      logic [31:0] release_ok_count;
      logic [31:0] alloc_fail_count;
      logic [31:0] release_reject_count;
   } rsp_type;

   // Next generation for a slot; zero is reserved for invalid handles.
   function automatic logic [GEN_WIDTH-1:0] gen_advance(input logic [GEN_WIDTH-1:0] g);
      logic [GEN_WIDTH-1:0] n;
      n = g + 1'b1;
      return (n == '0) ? GEN_WIDTH'(1) : n;
   endfunction

endpackage

FILE: hw/rtl/generational_slot_allocator_unit.sv
// An accepted request passes through S_LOOK and S_EXEC; its result strobe is registered.
// No new request is taken until the last is done; a free-stack read, then a metadata
// read at the chosen slot, then the update go through one-read, one-write memories.
// Reset: synchronous; afterwards a clearing pass over every slot rebuilds the free stack
// and clears the generation and in-use memories, busy staying high meanwhile.
// The receiver cannot stall: each result is shown for exactly one cycle.
module generational_slot_allocator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gsa_pkg::req_type  req_payload,
   output logic              rsp_valid,
   output gsa_pkg::rsp_type  rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import gsa_pkg::*;

   state_type            state_ff, state_in;
   logic [SLOT_W-1:0]    clr_ff, clr_in;
   req_type              req_ff, req_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [TOP_W-1:0]     free_top_ff, free_top_in;
   logic [TOP_W-1:0]     in_use_ff, in_use_in;
   logic [31:0]          alloc_ok_ff, alloc_ok_in;
   logic [31:0]          release_ok_ff, release_ok_in;
   logic [31:0]          alloc_fail_ff, alloc_fail_in;
   logic [31:0]          release_reject_ff, release_reject_in;
   logic                 pool_kind_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [SLOT_W-1:0]    stack_mem [SLOTS];
   logic [GEN_WIDTH-1:0] gen_mem [SLOTS];
   logic                 use_mem [SLOTS];

   logic [SLOT_W-1:0]    stk_rd_ff;
   logic [GEN_WIDTH-1:0] gen_rd_ff;
   logic                 use_rd_ff;

   logic                 stk_we, gen_we, use_we, use_wd;
   logic [SLOT_W-1:0]    stk_wa, stk_wd, stk_ra, gen_wa, use_wa, meta_ra;
   logic [GEN_WIDTH-1:0] gen_wd, gen_next;
   logic [2:0]           chk;
   logic                 csr_write;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == 1'(REG_POOL_KIND)) ? {31'b0, pool_kind_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_kind_ff <= 1'b0;
      end else if (csr_write && csr_paddr[2] == 1'(REG_POOL_KIND)) begin
         pool_kind_ff <= csr_pwdata[0];
      end
   end

   // Memories.
   assign stk_ra  = SLOT_W'(free_top_ff - 1'b1);
   assign meta_ra = (req_ff.mode == MODE_ALLOC) ? stk_rd_ff : req_ff.handle_slot[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stack_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (gen_we) begin
         gen_mem[gen_wa] <= gen_wd;
      end
      gen_rd_ff <= gen_mem[meta_ra];
   end

   always_ff @(posedge clock) begin
      if (use_we) begin
         use_mem[use_wa] <= use_wd;
      end
      use_rd_ff <= use_mem[meta_ra];
   end

   // Handle check, first failing test wins.
   assign gen_next = gen_advance(gen_rd_ff);

   always_comb begin
      if (req_ff.handle_generation == '0) begin
         chk = STAT_INVALID;
      end else if (req_ff.handle_kind != pool_kind_ff) begin
         chk = STAT_WRONG_KIND;
      end else if (req_ff.handle_slot >= 12'(SLOTS)) begin
         chk = STAT_OUT_OF_RANGE;
      end else if (req_ff.handle_generation != 32'(gen_rd_ff)) begin
         chk = STAT_STALE;
      end else if (!use_rd_ff) begin
         chk = STAT_ALREADY_FREE;
      end else begin
         chk = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_CLEAR;
         clr_ff            <= '0;
         free_top_ff       <= TOP_W'(SLOTS);
         in_use_ff         <= '0;
         alloc_ok_ff       <= '0;
         release_ok_ff     <= '0;
         alloc_fail_ff     <= '0;
         release_reject_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         clr_ff            <= clr_in;
         free_top_ff       <= free_top_in;
         in_use_ff         <= in_use_in;
         alloc_ok_ff       <= alloc_ok_in;
         release_ok_ff     <= release_ok_in;
         alloc_fail_ff     <= alloc_fail_in;
         release_reject_ff <= release_reject_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in          = state_ff;
      clr_in            = clr_ff;
      req_in            = req_ff;
      slot_in           = slot_ff;
      free_top_in       = free_top_ff;
      in_use_in         = in_use_ff;
      alloc_ok_in       = alloc_ok_ff;
      release_ok_in     = release_ok_ff;
      alloc_fail_in     = alloc_fail_ff;
      release_reject_in = release_reject_ff;
      rsp_valid_in      = 1'b0;
      rsp_in            = rsp_ff;
      stk_we            = 1'b0;
      stk_wa            = clr_ff;
      stk_wd            = SLOT_W'(SLOTS - 1) - clr_ff;
      gen_we            = 1'b0;
      gen_wa            = clr_ff;
      gen_wd            = '0;
      use_we            = 1'b0;
      use_wa            = clr_ff;
      use_wd            = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            // Stack entry i gets slot SLOTS-1-i so that slot 0 is popped first.
            stk_we = 1'b1;
            gen_we = 1'b1;
            use_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_payload;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            slot_in  = meta_ra;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in              = S_IDLE;
            rsp_valid_in          = 1'b1;
            rsp_in.status         = chk;
            rsp_in.out_kind       = 1'b0;
            rsp_in.out_slot       = '0;
            rsp_in.out_generation = '0;
            if (req_ff.mode == MODE_ALLOC) begin
               if (free_top_ff == '0) begin
                  rsp_in.status = STAT_EXHAUSTED;
                  alloc_fail_in = alloc_fail_ff + 1'b1;
               end else begin
                  free_top_in           = free_top_ff - 1'b1;
                  gen_we                = 1'b1;
                  gen_wa                = slot_ff;
                  gen_wd                = gen_next;
                  use_we                = 1'b1;
                  use_wa                = slot_ff;
                  use_wd                = 1'b1;
                  in_use_in             = in_use_ff + 1'b1;
                  alloc_ok_in           = alloc_ok_ff + 1'b1;
                  rsp_in.status         = STAT_OK;
                  rsp_in.out_kind       = pool_kind_ff;
                  rsp_in.out_slot       = 10'(slot_ff);
                  rsp_in.out_generation = 32'(gen_next);
               end
            end else if (req_ff.mode == MODE_RELEASE) begin
               if (chk != STAT_OK) begin
                  release_reject_in = release_reject_ff + 1'b1;
               end else begin
                  if (free_top_ff < TOP_W'(SLOTS)) begin
                     stk_we      = 1'b1;
                     stk_wa      = SLOT_W'(free_top_ff);
                     stk_wd      = slot_ff;
                     free_top_in = free_top_ff + 1'b1;
                  end
                  use_we = 1'b1;
                  use_wa = slot_ff;
                  use_wd = 1'b0;
                  if (in_use_ff != '0) begin
                     in_use_in = in_use_ff - 1'b1;
                  end
                  release_ok_in = release_ok_ff + 1'b1;
               end
            end
            rsp_in.free_count           = 11'(free_top_in);
            rsp_in.allocated_count      = 11'(in_use_in);
            rsp_in.alloc_ok_count       = alloc_ok_in;
            rsp_in.release_ok_count     = release_ok_in;
            rsp_in.alloc_fail_count     = alloc_fail_in;
            rsp_in.release_reject_count = release_reject_in;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hw/rtl/gsa_checker.sv
module gsa_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input gsa_pkg::rsp_type rsp_payload
);
   import gsa_pkg::*;

   // Every accepted request yields a result strobe.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("result missing three cycles after a request beat");

   // The block stays busy until the result of a request is shown.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 busy)
      else $error("busy dropped while a request was in flight");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // Free slots and allocated slots always account for the whole pool.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_payload.free_count}
                     + {1'b0, rsp_payload.allocated_count}) == 12'(SLOTS))
      else $error("free and allocated counts do not sum to the pool size");

   a_no_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STAT_OK) |-> rsp_payload.out_generation == '0)
      else $error("failed request returned a generation");

endmodule

bind generational_slot_allocator_unit gsa_checker u_gsa_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

FILE: verif/allocator_checker.sv
module allocator_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  gsa_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  gsa_pkg::rsp_type rsp_payload,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   input  logic [31:0]      csr_prdata,
   input  logic             csr_pready,
   output int               failures,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import gsa_pkg::*;

   localparam logic [2:0] POOL_KIND_ADDR = 3'(4 * REG_POOL_KIND);

   // Shadow copy of the allocator state.
   logic                 pool_kind;
   logic [SLOT_W-1:0]    free_stack [SLOTS];
   logic [TOP_W-1:0]     free_top;
   logic [GEN_WIDTH-1:0] slot_gen [SLOTS];
   logic                 slot_used [SLOTS];
   logic [TOP_W-1:0]     in_use;
   logic [31:0]          alloc_ok_total;
   logic [31:0]          release_ok_total;
   logic [31:0]          alloc_fail_total;
   logic [31:0]          release_reject_total;

   rsp_type awaited_rsp [$];

   task automatic clear_pool();
      for (int i = 0; i < SLOTS; i++) begin
         free_stack[i] = SLOT_W'(SLOTS - 1 - i);
         slot_gen[i]   = '0;
         slot_used[i]  = 1'b0;
      end
      pool_kind            = 1'b0;
      free_top             = TOP_W'(SLOTS);
      in_use               = '0;
      alloc_ok_total       = '0;
      release_ok_total     = '0;
      alloc_fail_total     = '0;
      release_reject_total = '0;
   endtask

   function automatic logic [GEN_WIDTH-1:0] next_generation(input logic [GEN_WIDTH-1:0] g);
      logic [GEN_WIDTH-1:0] bumped;
      bumped = g + 1'b1;
      if (bumped == '0) begin
         bumped = GEN_WIDTH'(1);
      end
      return bumped;
   endfunction

   // The checks run in a fixed order and the first failing one decides the status.
   function automatic logic [2:0] handle_verdict(input req_type rq);
      logic [SLOT_W-1:0] idx;
      idx = rq.handle_slot[SLOT_W-1:0];
      if (rq.handle_generation == '0) begin
         return STAT_INVALID;
      end else if (rq.handle_kind != pool_kind) begin
         return STAT_WRONG_KIND;
      end else if (int'(rq.handle_slot) >= SLOTS) begin
         return STAT_OUT_OF_RANGE;
      end else if (rq.handle_generation != slot_gen[idx]) begin
         return STAT_STALE;
      end else if (!slot_used[idx]) begin
         return STAT_ALREADY_FREE;
      end
      return STAT_OK;
   endfunction

   function automatic rsp_type apply_request(input req_type rq);
      rsp_type           r;
      logic [SLOT_W-1:0] s;
      r = '0;
      if (rq.mode == MODE_ALLOC) begin
         if (free_top == '0) begin
            r.status = STAT_EXHAUSTED;
            alloc_fail_total++;
         end else begin
            s           = free_stack[SLOT_W'(free_top - 1'b1)];
            free_top    = free_top - 1'b1;
            slot_gen[s] = next_generation(slot_gen[s]);
            slot_used[s] = 1'b1;
            in_use      = in_use + 1'b1;
            alloc_ok_total++;
            r.status         = STAT_OK;
            r.out_kind       = pool_kind;
            r.out_slot       = s;
            r.out_generation = slot_gen[s];
         end
      end else if (rq.mode == MODE_RELEASE) begin
         r.status = handle_verdict(rq);
         if (r.status != STAT_OK) begin
            release_reject_total++;
         end else begin
            if (int'(free_top) < SLOTS) begin
               free_stack[free_top[SLOT_W-1:0]] = rq.handle_slot[SLOT_W-1:0];
               free_top = free_top + 1'b1;
            end
            slot_used[rq.handle_slot[SLOT_W-1:0]] = 1'b0;
            if (in_use != '0) begin
               in_use = in_use - 1'b1;
            end
            release_ok_total++;
         end
      end else begin
         // Validate, and the spare mode code, only report.
         r.status = handle_verdict(rq);
      end
      r.free_count           = free_top;
      r.allocated_count      = in_use;
      r.alloc_ok_count       = alloc_ok_total;
      r.release_ok_count     = release_ok_total;
      r.alloc_fail_count     = alloc_fail_total;
      r.release_reject_count = release_reject_total;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         clear_pool();
         awaited_rsp.delete();
         pending = 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               $error("result beat with nothing outstanding, status %0d", rsp_payload.status);
               failures++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_payload.status));
               check_field("out_kind", 32'(want.out_kind), 32'(rsp_payload.out_kind));
               check_field("out_slot", 32'(want.out_slot), 32'(rsp_payload.out_slot));
               check_field("out_generation", want.out_generation, rsp_payload.out_generation);
               check_field("free_count", 32'(want.free_count),
                           32'(rsp_payload.free_count));
               check_field("allocated_count", 32'(want.allocated_count),
                           32'(rsp_payload.allocated_count));
               check_field("alloc_ok_count", want.alloc_ok_count, rsp_payload.alloc_ok_count);
               check_field("release_ok_count", want.release_ok_count,
                           rsp_payload.release_ok_count);
               check_field("alloc_fail_count", want.alloc_fail_count,
                           rsp_payload.alloc_fail_count);
               check_field("release_reject_count", want.release_reject_count,
                           rsp_payload.release_reject_count);
            end
         end
         if (start && !busy) begin
            awaited_rsp.insert(awaited_rsp.size(), apply_request(req_payload));
         end
         if (csr_psel && csr_penable && csr_pready && csr_paddr == POOL_KIND_ADDR) begin
            if (csr_pwrite) begin
               pool_kind = csr_pwdata[0];
            end else begin
               check_field("pool_kind", {31'b0, pool_kind}, csr_prdata);
            end
         end
         pending = awaited_rsp.size();
      end
   end

endmodule

FILE: verif/generational_slot_allocator_unit_tb.sv
module generational_slot_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gsa_pkg::*;

   localparam logic [1:0] MODE_CHECK = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [2:0] POOL_KIND_ADDR = 3'(4 * REG_POOL_KIND);
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic        kind;
      logic [11:0] slot;
      logic [31:0] generation;
   } handle_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int failures;
   int pending;
   int cycle_count;
   int burst_left;
   logic cur_kind;

   // Handles handed out by the block and not yet released, and recently released ones.
   handle_type live_q [$];
   handle_type freed_q [$];

   always #5ns clock = ~clock;

   generational_slot_allocator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   allocator_checker chk (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .pending     (pending)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("generational_slot_allocator_unit_tb NOT OK");
         $finish;
      end
   end

   // Learn new handles from successful allocations so that releases can be well formed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_payload.status == STAT_OK
          && rsp_payload.out_generation != '0) begin
         live_q.insert(live_q.size(), {rsp_payload.out_kind, 2'b00, rsp_payload.out_slot,
                                       rsp_payload.out_generation});
      end
   end

   task automatic issue(input req_type rq);
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic pause_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic csr_access(input logic write, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= POOL_KIND_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_pool_kind(input logic k);
      logic [31:0] value;
      value    = $urandom();
      value[0] = k;
      drain();
      csr_access(1'b1, value);
      csr_access(1'b0, '0);
      cur_kind = k;
   endtask

   function automatic req_type make_req(input logic [1:0] mode, input handle_type h);
      req_type rq;
      rq.mode              = mode;
      rq.handle_kind       = h.kind;
      rq.handle_slot       = h.slot;
      rq.handle_generation = h.generation;
      return rq;
   endfunction

   function automatic req_type noise_req();
      req_type rq;
      rq.mode        = 2'($urandom_range(3));
      rq.handle_kind = 1'($urandom_range(1));
      case ($urandom_range(2))
         0: rq.handle_slot = 12'($urandom_range(4095));
         1: rq.handle_slot = 12'($urandom_range(1023));
         default: rq.handle_slot = 12'($urandom_range(4095, 1024));
      endcase
      case ($urandom_range(3))
         0: rq.handle_generation = '0;
         1: rq.handle_generation = $urandom();
         2: rq.handle_generation = 32'($urandom_range(3, 1));
         default: rq.handle_generation = '1;
      endcase
      return rq;
   endfunction

   task automatic run_segment(input int count, input int alloc_pct, input int release_pct);
      int         r;
      int         idx;
      handle_type h;
      req_type    rq;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < alloc_pct) begin
            rq      = noise_req();
            rq.mode = MODE_ALLOC;
         end else if (r < alloc_pct + release_pct && live_q.size() > 0) begin
            idx    = $urandom_range(live_q.size() - 1);
            h      = live_q[idx];
            live_q.delete(idx);
            h.kind = cur_kind;
            rq     = make_req(MODE_RELEASE, h);
            freed_q.insert(freed_q.size(), h);
            if (freed_q.size() > 64) begin
               void'(freed_q.pop_front());
            end
         end else if (r < alloc_pct + release_pct + 5 && live_q.size() > 0) begin
            h      = live_q[$urandom_range(live_q.size() - 1)];
            h.kind = ($urandom_range(7) == 0) ? ~cur_kind : cur_kind;
            rq     = make_req($urandom_range(1) ? MODE_CHECK : MODE_SPARE, h);
         end else if (r < alloc_pct + release_pct + 8 && freed_q.size() > 0) begin
            // Released handles come back as stale or already free.
            h      = freed_q[$urandom_range(freed_q.size() - 1)];
            h.kind = cur_kind;
            rq     = make_req($urandom_range(1) ? MODE_RELEASE : MODE_CHECK, h);
         end else begin
            rq = noise_req();
         end
         if (burst_left == 0) begin
            if ($urandom_range(3) == 0) begin
               burst_left = $urandom_range(120, 40);
            end else begin
               pause_cycles($urandom_range(6, 1));
               burst_left = $urandom_range(16, 1);
            end
         end
         issue(rq);
         burst_left--;
      end
   endtask

   initial begin : stimulus
      handle_type h0;
      handle_type h1;
      handle_type h2;
      handle_type probe;
      req_type    rq;

      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cur_kind    = 1'b0;
      burst_left  = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Validation order on an empty pool.
      issue(make_req(MODE_CHECK, '{kind: 1'b1, slot: 12'hFFF, generation: '0}));
      issue(make_req(MODE_CHECK, '{kind: 1'b1, slot: 12'd5, generation: '1}));
      issue(make_req(MODE_CHECK, '{kind: 1'b0, slot: 12'hFFF, generation: 32'd1}));
      issue(make_req(MODE_CHECK, '{kind: 1'b0, slot: 12'd1024, generation: 32'd1}));
      issue(make_req(MODE_CHECK, '{kind: 1'b0, slot: 12'd0, generation: 32'd1}));
      issue(make_req(MODE_RELEASE, '{kind: 1'b0, slot: 12'd1023, generation: '1}));
      rq = '0;
      rq.mode = MODE_ALLOC;
      repeat (3) issue(rq);
      drain();

      h0 = live_q[0];
      h1 = live_q[1];
      h2 = live_q[2];
      live_q.delete(0);
      freed_q.insert(freed_q.size(), h0);
      issue(make_req(MODE_CHECK, h0));
      issue(make_req(MODE_RELEASE, h0));
      issue(make_req(MODE_RELEASE, h0));
      issue(make_req(MODE_SPARE, h1));
      probe      = h1;
      probe.kind = ~h1.kind;
      issue(make_req(MODE_RELEASE, probe));
      probe            = h1;
      probe.generation = h1.generation + 1'b1;
      issue(make_req(MODE_RELEASE, probe));
      issue(rq);
      drain();

      // The slot released above is handed out again, so the old handle is now stale.
      issue(make_req(MODE_RELEASE, h0));
      issue(make_req(MODE_RELEASE, '{kind: 1'b0, slot: 12'd1023, generation: '0}));
      rq = '1;
      rq.mode = MODE_ALLOC;
      issue(rq);
      issue(make_req(MODE_CHECK, h2));
      drain();

      run_segment(700, 85, 5);
      set_pool_kind(1'b1);
      run_segment(600, 90, 3);
      set_pool_kind(1'b0);
      run_segment(550, 15, 55);

      drain();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("generational_slot_allocator_unit_tb OK");
      end else begin
         $display("generational_slot_allocator_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/gsa_pkg.sv
hw/rtl/generational_slot_allocator_unit.sv
hw/rtl/gsa_checker.sv
verif/allocator_checker.sv
verif/generational_slot_allocator_unit_tb.sv
